// File: src/tsw_pkg.sv
// shared widths, fixed-point constants and register codes for the stdp weight update
// no dependencies
`default_nettype none

package tsw_pkg;

  localparam int unsigned TraceW = 17;
  localparam int unsigned RateW  = 16;
  localparam int unsigned WeightW = 18;
  localparam int unsigned SumW   = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [TraceW-1:0]         trace_t;
  typedef logic [RateW-1:0]          rate_t;
  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic signed [SumW-1:0]    sum_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  localparam trace_t TraceOne = trace_t'(65536);

  localparam weight_t WeightMax = weight_t'(131071);
  localparam weight_t WeightMin = weight_t'(-131072);
  localparam sum_t    SumMax    = sum_t'(32'sh7fff_ffff);
  localparam sum_t    SumMin    = sum_t'(32'sh8000_0000);

  localparam cfg_idx_t CfgTraceDecay = 2'd0;
  localparam cfg_idx_t CfgLtpRate    = 2'd1;
  localparam cfg_idx_t CfgLtdRate    = 2'd2;

  localparam rate_t TraceDecayRst = rate_t'(39322);
  localparam rate_t LtpRateRst    = rate_t'(6554);
  localparam rate_t LtdRateRst    = rate_t'(6554);

endpackage

`default_nettype wire

// File: src/trace_stdp_weight_update.sv
// one item per cycle sustained while the output is not stalled
// stage 1 decays the traces and forms the rate products, stage 2 the trace products,
// stage 3 adds and saturates into the output; stage 1 holds four multipliers, stage 2 two
// a stalled output backs up the stages, bubbles are squeezed out
// reset clears the stage valid bits and loads the default decay and rates
// depends on tsw_pkg
`default_nettype none

module trace_stdp_weight_update (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire tsw_pkg::cfg_idx_t cfg_index_i,
  input  wire tsw_pkg::rate_t   cfg_data_i,
  // input items
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             pre_spike_i,
  input  wire logic             post_spike_i,
  input  wire tsw_pkg::trace_t  pre_trace_old_i,
  input  wire tsw_pkg::trace_t  post_trace_old_i,
  input  wire tsw_pkg::weight_t weight_old_i,
  input  wire tsw_pkg::sum_t    dw_sum_old_i,
  // result items
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output tsw_pkg::trace_t       pre_trace_new_o,
  output tsw_pkg::trace_t       post_trace_new_o,
  output tsw_pkg::weight_t      weight_new_o,
  output tsw_pkg::sum_t         dw_sum_new_o
);
  import tsw_pkg::*;

  rate_t decay_q, ltp_q, ltd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= TraceDecayRst;
      ltp_q   <= LtpRateRst;
      ltd_q   <= LtdRateRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTraceDecay: decay_q <= cfg_data_i;
        CfgLtpRate:    ltp_q   <= cfg_data_i;
        CfgLtdRate:    ltd_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage enables, a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // ---------------- stage 1 ----------------
  logic [32:0]         pre_dec_prod, post_dec_prod;
  trace_t              pre_dec, post_dec, pre_tr_d, post_tr_d;
  logic signed [18:0]  one_minus_w;
  logic signed [35:0]  a_prod;
  logic signed [34:0]  b_prod;

  assign pre_dec_prod  = pre_trace_old_i * {1'b0, decay_q};
  assign post_dec_prod = post_trace_old_i * {1'b0, decay_q};

  always_comb begin
    pre_dec  = pre_dec_prod[32:16];
    post_dec = post_dec_prod[32:16];
    // a trace above one can decay to more than one
    if (pre_dec > TraceOne) pre_dec = TraceOne;
    if (post_dec > TraceOne) post_dec = TraceOne;
    pre_tr_d  = pre_spike_i  ? TraceOne : pre_dec;
    post_tr_d = post_spike_i ? TraceOne : post_dec;
  end

  assign one_minus_w = 19'sd65536 - 19'(weight_old_i);
  assign a_prod = $signed({1'b0, ltp_q}) * one_minus_w;
  assign b_prod = $signed({1'b0, ltd_q}) * weight_old_i;

  logic               s1_pre_q, s1_post_q;
  trace_t             s1_pre_tr_q, s1_post_tr_q;
  logic signed [18:0] s1_a_q;
  logic signed [17:0] s1_b_q;
  weight_t            s1_w_q;
  sum_t               s1_sum_q;

  // slices of the products are floor shifts by 16
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_pre_q     <= pre_spike_i;
      s1_post_q    <= post_spike_i;
      s1_pre_tr_q  <= pre_tr_d;
      s1_post_tr_q <= post_tr_d;
      s1_a_q       <= a_prod[34:16];
      s1_b_q       <= b_prod[33:16];
      s1_w_q       <= weight_old_i;
      s1_sum_q     <= dw_sum_old_i;
    end
  end

  // ---------------- stage 2 ----------------
  logic signed [36:0] pot_prod;
  logic signed [35:0] dep_prod;

  assign pot_prod = s1_a_q * $signed({1'b0, s1_pre_tr_q});
  assign dep_prod = s1_b_q * $signed({1'b0, s1_post_tr_q});

  trace_t             s2_pre_tr_q, s2_post_tr_q;
  logic signed [18:0] s2_pot_q;
  logic signed [17:0] s2_dep_q;
  weight_t            s2_w_q;
  sum_t               s2_sum_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_pre_tr_q  <= s1_pre_tr_q;
      s2_post_tr_q <= s1_post_tr_q;
      s2_pot_q     <= s1_post_q ? pot_prod[34:16] : '0;
      s2_dep_q     <= s1_pre_q  ? dep_prod[33:16] : '0;
      s2_w_q       <= s1_w_q;
      s2_sum_q     <= s1_sum_q;
    end
  end

  // ---------------- stage 3 ----------------
  logic signed [19:0] dw;
  logic signed [20:0] w_sum;
  logic signed [32:0] acc_sum;
  weight_t            w_sat;
  sum_t               acc_sat;

  assign dw      = 20'(s2_pot_q) - 20'(s2_dep_q);
  assign w_sum   = 21'(s2_w_q) + 21'(dw);
  assign acc_sum = 33'(s2_sum_q) + 33'(dw);

  always_comb begin
    priority if (w_sum > 21'(WeightMax)) w_sat = WeightMax;
    else if (w_sum < 21'(WeightMin))      w_sat = WeightMin;
    else                                  w_sat = w_sum[WeightW-1:0];
    priority if (acc_sum > 33'(SumMax)) acc_sat = SumMax;
    else if (acc_sum < 33'(SumMin))      acc_sat = SumMin;
    else                                 acc_sat = acc_sum[SumW-1:0];
  end

  trace_t  out_pre_tr_q, out_post_tr_q;
  weight_t out_w_q;
  sum_t    out_sum_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_pre_tr_q  <= s2_pre_tr_q;
      out_post_tr_q <= s2_post_tr_q;
      out_w_q       <= w_sat;
      out_sum_q     <= acc_sat;
    end
  end

  assign out_valid_o      = v3_q;
  assign pre_trace_new_o  = out_pre_tr_q;
  assign post_trace_new_o = out_post_tr_q;
  assign weight_new_o     = out_w_q;
  assign dw_sum_new_o     = out_sum_q;

endmodule

`default_nettype wire

// File: src/tsw_checker.sv
// port-level checks for the stdp weight update, bound to the top level
// depends on tsw_pkg and trace_stdp_weight_update
`default_nettype none

module tsw_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             pre_spike_i,
  input wire logic             post_spike_i,
  input wire tsw_pkg::weight_t weight_old_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire tsw_pkg::trace_t  pre_trace_new_o,
  input wire tsw_pkg::weight_t weight_new_o
);
  import tsw_pkg::*;

  // a held result keeps its weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(weight_new_o))
    else $error("stalled result changed");

  // input only backs up when the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // a presynaptic spike resets the trace to one at the output, checked when the output flows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && pre_spike_i) ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o && pre_trace_new_o == TraceOne)
    else $error("spiking trace not set to one");

  // with no spike the weight passes through unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !pre_spike_i && !post_spike_i)
    ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o && weight_new_o == $past(weight_old_i, 3))
    else $error("weight changed without a spike");

endmodule

bind trace_stdp_weight_update tsw_checker u_tsw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .pre_spike_i    (pre_spike_i),
  .post_spike_i   (post_spike_i),
  .weight_old_i   (weight_old_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pre_trace_new_o(pre_trace_new_o),
  .weight_new_o   (weight_new_o)
);

`default_nettype wire
